/* src/btd_pkg.sv */
// ----------------------------------------------------------------------------
// btd_pkg
// Shared types for the bytea text decoder: the queue entry that carries the
// bytes one character produced from the front part to the back part.
// ----------------------------------------------------------------------------
`default_nettype none

package btd_pkg;

    // number of decoded bytes in one entry
    typedef enum logic [1:0]
    {
        CNT_NONE = 2'd0,
        CNT_ONE  = 2'd1,
        CNT_TWO  = 2'd2
    } byte_cnt_t;

    typedef struct packed
    {
        logic [7:0] byte0;
        logic [7:0] byte1;
        byte_cnt_t  cnt;
        logic       fin;
    } btd_entry_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } btd_fifo_status_t;

endpackage

`default_nettype wire

/* src/btd_front.sv */
// ----------------------------------------------------------------------------
// btd_front
// Character front part: holds the format and lookahead state, decodes one
// character a beat into zero to two bytes and queues them with the end flag.
// ----------------------------------------------------------------------------
`default_nettype none

module btd_front
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       char_valid,
    output logic                      char_stall,
    input  wire [7:0]                 char_in,
    input  wire                       final_char,
    input  wire btd_pkg::btd_fifo_status_t fifo_status,
    output logic                      push,
    output btd_pkg::btd_entry_t       push_entry
);
    import btd_pkg::*;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LA        = 8'h61;
    localparam logic [7:0] CH_LF        = 8'h66;
    localparam logic [7:0] CH_UA        = 8'h41;
    localparam logic [7:0] CH_UF        = 8'h46;
    localparam logic [3:0] HEX_ALPHA_OFS = 4'd9;
    localparam logic [1:0] OCT_MAX      = 2'd3;

    typedef enum logic [1:0]
    {
        PH_START  = 2'd0,
        PH_ESCAPE = 2'd1,
        PH_HEX    = 2'd2
    } phase_t;

    typedef struct packed
    {
        phase_t     phase;
        logic       char_index_one;
        logic       backslash_pending;
        logic [1:0] octal_count;
        logic [7:0] octal_accum;
        logic [3:0] high_nibble;
        logic       nibble_held;
    } state_t;

    typedef struct packed
    {
        state_t     st;
        byte_cnt_t  cnt;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } work_t;

    localparam state_t STATE_RESET = '{
        phase: PH_START, char_index_one: 1'b0, backslash_pending: 1'b0,
        octal_count: 2'd0, octal_accum: 8'd0, high_nibble: 4'd0, nibble_held: 1'b0
    };

    state_t state_reg;
    state_t state_next;
    work_t  step;
    logic   take;

    function automatic logic is_octal(input logic [7:0] c);
        is_octal = (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if ((c >= CH_ZERO) && (c <= CH_NINE))
            v = c[3:0];
        else if (((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF)))
            v = c[3:0] + HEX_ALPHA_OFS;
        hex_digit = v;
    endfunction

    // at most two bytes are kept, a third is dropped
    function automatic work_t emit(input work_t w, input logic [7:0] b);
        work_t r;
        r = w;
        unique case (r.cnt)
            CNT_NONE:
            begin
                r.byte0 = b;
                r.cnt   = CNT_ONE;
            end
            CNT_ONE:
            begin
                r.byte1 = b;
                r.cnt   = CNT_TWO;
            end
            default:
            begin
                r.cnt = CNT_TWO;
            end
        endcase
        emit = r;
    endfunction

    function automatic work_t escape_char(input work_t w, input logic [7:0] c);
        work_t r;
        logic  done;
        r    = w;
        done = 1'b0;
        if (r.st.octal_count != 2'd0)
        begin
            if (is_octal(c) && (r.st.octal_count < OCT_MAX))
            begin
                r.st.octal_accum = {r.st.octal_accum[4:0], c[2:0]};
                r.st.octal_count = r.st.octal_count + 2'd1;
                if (r.st.octal_count == OCT_MAX)
                begin
                    r = emit(r, r.st.octal_accum);
                    r.st.octal_count = 2'd0;
                    r.st.octal_accum = 8'd0;
                end
                done = 1'b1;
            end
            else
            begin
                r = emit(r, r.st.octal_accum);
                r.st.octal_count = 2'd0;
                r.st.octal_accum = 8'd0;
            end
        end
        else if (r.st.backslash_pending)
        begin
            r.st.backslash_pending = 1'b0;
            if (c == CH_BACKSLASH)
            begin
                r    = emit(r, CH_BACKSLASH);
                done = 1'b1;
            end
            else if (is_octal(c))
            begin
                r.st.octal_accum = {5'd0, c[2:0]};
                r.st.octal_count = 2'd1;
                done = 1'b1;
            end
            else
            begin
                r = emit(r, CH_BACKSLASH);
            end
        end
        if (!done)
        begin
            if (c == CH_BACKSLASH)
                r.st.backslash_pending = 1'b1;
            else
                r = emit(r, c);
        end
        escape_char = r;
    endfunction

    always_comb
    begin
        step       = '0;
        step.st    = state_reg;
        step.cnt   = CNT_NONE;
        if (state_reg.phase == PH_START)
        begin
            if (!state_reg.char_index_one)
            begin
                step.st.backslash_pending = 1'b0;
                step.st.octal_count       = 2'd0;
                step.st.octal_accum       = 8'd0;
                if ((char_in == CH_BACKSLASH) && !final_char)
                begin
                    step.st.char_index_one    = 1'b1;
                    step.st.backslash_pending = 1'b1;
                end
                else
                begin
                    step.st.phase = PH_ESCAPE;
                    step = escape_char(step, char_in);
                end
            end
            else
            begin
                step.st.char_index_one = 1'b0;
                if (char_in == CH_X)
                begin
                    step.st.phase             = PH_HEX;
                    step.st.backslash_pending = 1'b0;
                    step.st.nibble_held       = 1'b0;
                    step.st.high_nibble       = 4'd0;
                end
                else
                begin
                    step.st.phase             = PH_ESCAPE;
                    step.st.backslash_pending = 1'b1;
                    step.st.octal_count       = 2'd0;
                    step.st.octal_accum       = 8'd0;
                    step = escape_char(step, char_in);
                end
            end
        end
        else if (state_reg.phase == PH_HEX)
        begin
            if (!state_reg.nibble_held)
            begin
                step.st.high_nibble = hex_digit(char_in);
                step.st.nibble_held = 1'b1;
            end
            else
            begin
                step = emit(step, {state_reg.high_nibble, hex_digit(char_in)});
                step.st.nibble_held = 1'b0;
                step.st.high_nibble = 4'd0;
            end
        end
        else
        begin
            // unused phase code behaves as escape format
            step = escape_char(step, char_in);
        end

        // flush the escape lookahead on the last character, then return to the start state
        if (final_char)
        begin
            if (step.st.phase != PH_HEX)
            begin
                if (step.st.octal_count != 2'd0)
                    step = emit(step, step.st.octal_accum);
                else if (step.st.backslash_pending)
                    step = emit(step, CH_BACKSLASH);
            end
            step.st = STATE_RESET;
        end
    end

    assign char_stall = fifo_status.full;
    assign take       = char_valid && !fifo_status.full;
    assign push       = take && ((step.cnt != CNT_NONE) || final_char);
    assign state_next = take ? step.st : state_reg;

    always_comb
    begin
        push_entry.byte0 = step.byte0;
        push_entry.byte1 = step.byte1;
        push_entry.cnt   = step.cnt;
        push_entry.fin   = final_char;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* src/btd_fifo.sv */
// ----------------------------------------------------------------------------
// btd_fifo
// Short queue of decoded entries between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module btd_fifo
#(
    parameter int DEPTH = 4
)
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       push,
    input  wire btd_pkg::btd_entry_t  push_entry,
    input  wire                       pop,
    output btd_pkg::btd_entry_t       pop_entry,
    output btd_pkg::btd_fifo_status_t status
);
    import btd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    btd_entry_t    mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_entry    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* src/btd_back.sv */
// ----------------------------------------------------------------------------
// btd_back
// Result back part: takes queued entries and sends their bytes one beat at a
// time through an output register, with the end and run flags.
// ----------------------------------------------------------------------------
`default_nettype none

module btd_back
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire btd_pkg::btd_entry_t  pop_entry,
    input  wire btd_pkg::btd_fifo_status_t fifo_status,
    output logic                      pop,
    output logic                      byte_valid,
    input  wire                       byte_stall,
    output logic [7:0]                byte_out,
    output logic                      byte_present,
    output logic                      string_end,
    output logic                      run_last
);
    import btd_pkg::*;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       out_present_reg;
    logic       out_present_next;
    logic       out_end_reg;
    logic       out_end_next;
    logic       out_last_reg;
    logic       out_last_next;
    logic       second_reg;
    logic       second_next;
    logic [7:0] second_byte_reg;
    logic [7:0] second_byte_next;
    logic       second_fin_reg;
    logic       second_fin_next;
    logic       load;

    assign load = !out_valid_reg || !byte_stall;
    assign pop  = load && !second_reg && !fifo_status.empty;

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_byte_next    = out_byte_reg;
        out_present_next = out_present_reg;
        out_end_next     = out_end_reg;
        out_last_next    = out_last_reg;
        second_next      = second_reg;
        second_byte_next = second_byte_reg;
        second_fin_next  = second_fin_reg;
        if (load)
        begin
            out_valid_next = 1'b0;
            if (second_reg)
            begin
                out_valid_next   = 1'b1;
                out_byte_next    = second_byte_reg;
                out_present_next = 1'b1;
                out_end_next     = second_fin_reg;
                out_last_next    = 1'b1;
                second_next      = 1'b0;
            end
            else if (!fifo_status.empty)
            begin
                out_valid_next = 1'b1;
                unique case (pop_entry.cnt)
                    CNT_TWO:
                    begin
                        out_byte_next    = pop_entry.byte0;
                        out_present_next = 1'b1;
                        out_end_next     = 1'b0;
                        out_last_next    = 1'b0;
                        second_next      = 1'b1;
                        second_byte_next = pop_entry.byte1;
                        second_fin_next  = pop_entry.fin;
                    end
                    CNT_ONE:
                    begin
                        out_byte_next    = pop_entry.byte0;
                        out_present_next = 1'b1;
                        out_end_next     = pop_entry.fin;
                        out_last_next    = 1'b1;
                    end
                    default:
                    begin
                        // empty final result of the string
                        out_byte_next    = 8'd0;
                        out_present_next = 1'b0;
                        out_end_next     = 1'b1;
                        out_last_next    = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg    <= out_byte_next;
        out_present_reg <= out_present_next;
        out_end_reg     <= out_end_next;
        out_last_reg    <= out_last_next;
        second_byte_reg <= second_byte_next;
        second_fin_reg  <= second_fin_next;
    end

    assign byte_valid   = out_valid_reg;
    assign byte_out     = out_byte_reg;
    assign byte_present = out_present_reg;
    assign string_end   = out_end_reg;
    assign run_last     = out_last_reg;

endmodule

`default_nettype wire

/* src/bytea_text_decoder.sv */
// ----------------------------------------------------------------------------
// bytea_text_decoder
// Streaming decoder of text-encoded binary strings (hex or escape format)
// into raw bytes, one character beat in, one byte beat out.
//
//   channel | handshake                | payload
//   --------+--------------------------+------------------------------------
//   char    | char_valid / char_stall  | char_in, final_char
//   byte    | byte_valid / byte_stall  | byte_out, byte_present,
//           |                          | string_end, run_last
//
// a character is decoded in the cycle it is taken and its bytes are queued
// one character beat a cycle is taken while the queue has room
// the output register sends one byte beat a cycle while it has bytes and
// byte_stall is low, so the two bytes of a character leave one after the
// other; the first byte goes from the queue entry into the output register
// reset empties the queue and returns the decoder to the start of a string
// ----------------------------------------------------------------------------
`default_nettype none

module bytea_text_decoder
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        char_valid,
    output logic       char_stall,
    input  wire [7:0]  char_in,
    input  wire        final_char,
    output logic       byte_valid,
    input  wire        byte_stall,
    output logic [7:0] byte_out,
    output logic       byte_present,
    output logic       string_end,
    output logic       run_last
);
    import btd_pkg::*;

    btd_fifo_status_t fifo_status;
    btd_entry_t       push_entry;
    btd_entry_t       pop_entry;
    logic             push;
    logic             pop;

    btd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_in     (char_in),
        .final_char  (final_char),
        .fifo_status (fifo_status),
        .push        (push),
        .push_entry  (push_entry)
    );

    btd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (fifo_status)
    );

    btd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_entry    (pop_entry),
        .fifo_status  (fifo_status),
        .pop          (pop),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_out     (byte_out),
        .byte_present (byte_present),
        .string_end   (string_end),
        .run_last     (run_last)
    );

endmodule

`default_nettype wire
